// ----- rtl/core/tcw_pkg.sv -----
// Text console writer: shared widths, command codes, character codes and the
// control/status structs between the controller and the datapath.
// No dependencies.
package tcw_pkg;

  // Default screen geometry
  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  // Field widths of the request and result channels
  localparam int CMD_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int ATTR_W  = 8;
  localparam int TROW_W  = 5;
  localparam int TCOL_W  = 7;
  localparam int CELL_W  = CHAR_W + ATTR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ATTR = 1'b1;

  // Special characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // What a memory sweep writes
  typedef enum logic [1:0] {
    SWP_INIT,
    SWP_CLEAR,
    SWP_SCROLL
  } sweep_mode_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        exec;
    logic        sweep_en;
    sweep_mode_t sweep_mode;
    logic        out_load;
  } tcw_ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic needs_scroll;
    logic sweep_last;
    logic out_free;
  } tcw_sts_t;

endpackage

// ----- rtl/core/tcw_in_if.sv -----
// Request channel of the text console writer: valid/ready plus command fields.
// Depends on tcw_pkg.
interface tcw_in_if import tcw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [TROW_W-1:0]  target_row;
  logic [TCOL_W-1:0]  target_col;

  modport source (
    output valid, cmd, char_code, fg_color, bg_color, target_row, target_col,
    input  ready
  );
  modport sink (
    input  valid, cmd, char_code, fg_color, bg_color, target_row, target_col,
    output ready
  );
endinterface

// ----- rtl/core/tcw_out_if.sv -----
// Result channel of the text console writer: valid/ready plus cursor and cell.
// Depends on tcw_pkg.
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TROW_W-1:0] cursor_row;
  logic [TCOL_W-1:0] cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (
    output valid, cursor_row, cursor_col, cell_char, cell_attr,
    input  ready
  );
  modport sink (
    input  valid, cursor_row, cursor_col, cell_char, cell_attr,
    output ready
  );
endinterface

// ----- rtl/core/tcw_ctrl.sv -----
// Text console writer controller: request sequencing, memory sweeps and
// result hand-off. Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tcw_sts_t sts,
  output tcw_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t      state_r, state_nxt;
  sweep_mode_t sweep_mode_r, sweep_mode_nxt;

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    sweep_mode_nxt = sweep_mode_r;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.sweep_mode = sweep_mode_r;
    case (state_r)
      S_INIT: begin
        ctl.sweep_en = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        if (sts.cmd == CMD_CLEAR) begin
          sweep_mode_nxt = SWP_CLEAR;
          state_nxt      = S_SWEEP;
        end else if (sts.needs_scroll) begin
          sweep_mode_nxt = SWP_SCROLL;
          state_nxt      = S_SWEEP;
        end else if (sts.cmd == CMD_READ) begin
          // read data lands in the next cycle
          state_nxt = S_FINISH;
        end else if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SWEEP: begin
        ctl.sweep_en = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      sweep_mode_r <= SWP_INIT;
    end else begin
      state_r      <= state_nxt;
      sweep_mode_r <= sweep_mode_nxt;
    end
  end

endmodule

// ----- rtl/core/tcw_dpath.sv -----
// Text console writer datapath: screen memory, cursor, sweep counter,
// configuration registers and result register. Depends on tcw_pkg.
module tcw_dpath import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_ctl_t              ctl,
  output tcw_sts_t              sts,
  // request payload
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [COLOR_W-1:0]    in_fg_color,
  input  logic [COLOR_W-1:0]    in_bg_color,
  input  logic [TROW_W-1:0]     in_target_row,
  input  logic [TCOL_W-1:0]     in_target_col,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [TROW_W-1:0]     out_cursor_row,
  output logic [TCOL_W-1:0]     out_cursor_col,
  output logic [CHAR_W-1:0]     out_cell_char,
  output logic [ATTR_W-1:0]     out_cell_attr
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);

  localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);
  localparam logic [CLW-1:0] LAST_COL = CLW'(COLUMNS - 1);

  // Configuration registers
  logic [ATTR_W-1:0] clear_attr_r, scroll_attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_attr_r  <= 8'd7;
      scroll_attr_r <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLEAR_ATTR:  clear_attr_r  <= cfg_data;
        CFG_SCROLL_ATTR: scroll_attr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request capture, targets saturated to the screen
  cmd_t              cmd_r;
  logic [CHAR_W-1:0] ch_r;
  logic [ATTR_W-1:0] attr_r;
  logic [RW-1:0]     tr_sat_r;
  logic [CLW-1:0]    tc_sat_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_t'(in_cmd);
      ch_r     <= in_char_code;
      attr_r   <= {in_bg_color, in_fg_color};
      tr_sat_r <= (int'(in_target_row) >= ROWS) ? LAST_ROW : RW'(in_target_row);
      tc_sat_r <= (int'(in_target_col) >= COLUMNS) ? LAST_COL : CLW'(in_target_col);
    end
  end

  // Cursor: row, column and the linear address of the row start
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic [AW-1:0]  base_r, base_nxt;
  logic [AW-1:0]  cur_addr, bs_addr, tgt_base, rd_addr;
  logic           is_nl, is_bs;
  logic           needs_scroll, wr_put, wr_bs;

  assign cur_addr = base_r + AW'(col_r);
  assign bs_addr  = cur_addr - 1'b1;
  assign tgt_base = AW'(tr_sat_r * AW'(COLUMNS));
  assign rd_addr  = tgt_base + AW'(tc_sat_r);
  assign is_nl    = (ch_r == CH_NEWLINE);
  assign is_bs    = (ch_r == CH_BACKSPACE);

  // Command execution: cursor update and the one cell write it needs
  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    base_nxt     = base_r;
    needs_scroll = 1'b0;
    wr_put       = 1'b0;
    wr_bs        = 1'b0;
    if (ctl.exec) begin
      case (cmd_r)
        CMD_PUT: begin
          wr_put = !is_nl && !is_bs;
          if (is_nl || (!is_bs && col_r == LAST_COL)) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              needs_scroll = 1'b1;
            end else begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + AW'(COLUMNS);
            end
          end else if (is_bs) begin
            if (col_r != '0) begin
              col_nxt = col_r - 1'b1;
              wr_bs   = 1'b1;
            end else if (row_r != '0) begin
              row_nxt  = row_r - 1'b1;
              col_nxt  = LAST_COL;
              base_nxt = base_r - AW'(COLUMNS);
              wr_bs    = 1'b1;
            end
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
        CMD_MOVE: begin
          row_nxt  = tr_sat_r;
          col_nxt  = tc_sat_r;
          base_nxt = tgt_base;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      base_r <= '0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
    end
  end

  // Sweep counter; returns to zero after the last step
  logic [CW-1:0] cnt_r;
  logic          sweep_last;

  assign sweep_last = (ctl.sweep_mode == SWP_SCROLL) ? (cnt_r == CW'(CELLS))
                                                     : (cnt_r == CW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.sweep_en) begin
      cnt_r <= sweep_last ? '0 : cnt_r + 1'b1;
    end
  end

  // Memory port selection
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, rd_data_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {attr_r, ch_r};
    mem_re    = 1'b0;
    mem_raddr = rd_addr;
    if (wr_put) begin
      mem_we = 1'b1;
    end else if (wr_bs) begin
      mem_we    = 1'b1;
      mem_waddr = bs_addr;
      mem_wdata = '0;
    end else if (ctl.sweep_en) begin
      case (ctl.sweep_mode)
        SWP_CLEAR: begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata = {clear_attr_r, {CHAR_W{1'b0}}};
        end
        SWP_SCROLL: begin
          // read one row ahead, write the cell read in the previous cycle
          mem_re    = (cnt_r < CW'(CELLS - COLUMNS));
          mem_raddr = cnt_r[AW-1:0] + AW'(COLUMNS);
          mem_we    = (cnt_r != '0);
          mem_waddr = AW'(cnt_r - 1'b1);
          mem_wdata = (cnt_r <= CW'(CELLS - COLUMNS)) ? rd_data_r
                                                     : {scroll_attr_r, {CHAR_W{1'b0}}};
        end
        default: begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
          mem_wdata = '0;
        end
      endcase
    end
    if (ctl.exec && cmd_r == CMD_READ) begin
      mem_re = 1'b1;
    end
  end

  // Screen memory
  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Result register
  logic              out_valid_r;
  logic [TROW_W-1:0] out_row_r;
  logic [TCOL_W-1:0] out_col_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [ATTR_W-1:0] out_attr_r;
  logic              is_read;

  assign is_read = (cmd_r == CMD_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_row_r  <= TROW_W'(row_nxt);
      out_col_r  <= TCOL_W'(col_nxt);
      out_char_r <= is_read ? rd_data_r[CHAR_W-1:0] : '0;
      out_attr_r <= is_read ? rd_data_r[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

  // Status
  assign sts.cmd          = cmd_r;
  assign sts.needs_scroll = needs_scroll;
  assign sts.sweep_last   = sweep_last;
  assign sts.out_free     = !out_valid_r || out_ready;

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Text console writer top level: controller, datapath and channel hookup.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl and tcw_dpath.
//
// Text console of ROWS x COLUMNS 16-bit cells (attribute in bits 15..8,
// character in bits 7..0) with a cursor; every request gives one result
// with the cursor after the request, plus the cell contents for a read.
// After reset the screen memory is zeroed by a clearing pass over all
// ROWS*COLUMNS cells during which no request is taken; configuration
// writes are accepted at any time. One request is worked at a time.
// Put, newline, backspace and move make at most one cell write in the
// single-write screen memory, and a read waits on its registered read port.
// Clear and any request that scrolls walk the memory one cell per cycle.
// A result waiting in the output register does not block the next request
// until that request is ready to hand over its own result.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_in_if.sink                in_chan,
  tcw_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  tcw_ctl_t ctl;
  tcw_sts_t sts;
  logic     in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  tcw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_chan.cmd),
    .in_char_code   (in_chan.char_code),
    .in_fg_color    (in_chan.fg_color),
    .in_bg_color    (in_chan.bg_color),
    .in_target_row  (in_chan.target_row),
    .in_target_col  (in_chan.target_col),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_chan.ready),
    .out_valid      (out_chan.valid),
    .out_cursor_row (out_chan.cursor_row),
    .out_cursor_col (out_chan.cursor_col),
    .out_cell_char  (out_chan.cell_char),
    .out_cell_attr  (out_chan.cell_attr)
  );

  assign in_chan.ready = in_ready;

  // One request in flight: no accept right after an accept
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while previous one still in flight");

  // A captured request is executed in the next cycle
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> ctl.exec)
    else $error("captured request not executed");

  // The result register is only loaded when its slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> sts.out_free)
    else $error("result register overwritten");

endmodule
